>>> src/kmps_pkg.sv
// Shared constants and codes for the prefix-table string search block.
`timescale 1ns / 1ps
`default_nettype none

package kmps_pkg;

  localparam int PATTERN_MAX_DEF     = 64;
  localparam int TEXT_INDEX_BITS_DEF = 32;

  localparam logic [1:0] MODE_LOAD    = 2'd0;
  localparam logic [1:0] MODE_TEXT    = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LDT  = 4'b0010,
    S_CMP  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

endpackage

`default_nettype wire

>>> src/prefix_table_string_search.sv
// Top level of the prefix-table (KMP) first-occurrence string search block.
// Text byte: accepted in S_IDLE, then compared in S_CMP, with one prefix-table fallback step per mismatch
//   (one read of the pattern memory and the table memory per step).
// Pattern load at position 0 completes in S_IDLE; later positions go through S_LDT and S_CMP plus fallbacks.
// Restart, unused mode, ignored load, text with no pattern or text after a match complete in S_IDLE.
// Synchronous active-low reset clears control and search state (pattern length resets to 1); memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module prefix_table_string_search
  import kmps_pkg::*;
#(
  parameter int PATTERN_MAX     = PATTERN_MAX_DEF,
  parameter int TEXT_INDEX_BITS = TEXT_INDEX_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [6:0]  cfg_pattern_length,

  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_mode,
  input  wire logic [5:0]  in_pattern_position,
  input  wire logic [7:0]  in_symbol,

  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_found,
  output logic [31:0]      out_match_start,
  output logic [6:0]       out_matched_count
);

  localparam int IDX_W = $clog2(PATTERN_MAX);
  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  localparam int CMP_W = (LEN_W > 7) ? LEN_W : 7;
  localparam int TB    = TEXT_INDEX_BITS;

  // Control state
  state_t             state_r, state_nxt;
  logic [6:0]         plen_r, plen_nxt;
  logic [LEN_W-1:0]   build_len_r, build_len_nxt;
  logic [LEN_W-1:0]   match_r, match_nxt;
  logic [TB-1:0]      tpos_r, tpos_nxt;
  logic               found_r, found_nxt;
  logic [TB-1:0]      fms_r, fms_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Per-transaction working registers
  logic [LEN_W-1:0]   j_r, j_nxt;
  logic [7:0]         sym_r, sym_nxt;
  logic [IDX_W-1:0]   pos_r, pos_nxt;
  logic               load_r, load_nxt;

  // Result register
  logic               out_found_r;
  logic [31:0]        out_start_r;
  logic [6:0]         out_count_r;

  // Memory ports
  logic               p_we, t_we;
  logic [IDX_W-1:0]   p_waddr, t_waddr, p_raddr, t_raddr;
  logic [7:0]         p_wdata, p_rdata;
  logic [LEN_W-1:0]   t_wdata, t_rdata;

  // Datapath helpers
  logic [CMP_W-1:0]   m_raw;
  logic [LEN_W-1:0]   eff_len;
  logic [LEN_W-1:0]   j0;
  logic [LEN_W-1:0]   j_fin;
  logic               hit;
  logic               load_ok;
  logic               slot_free;
  logic               done;
  logic               out_load;
  logic [63:0]        fms_ext;

  kmps_ram #(
    .DEPTH (PATTERN_MAX),
    .WIDTH (8),
    .AW    (IDX_W)
  ) u_pattern_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  kmps_ram #(
    .DEPTH (PATTERN_MAX),
    .WIDTH (LEN_W),
    .AW    (IDX_W)
  ) u_prefix_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  // Effective pattern length: zero counts as one, clamp to capacity, then to loaded bytes.
  always_comb begin
    m_raw = (plen_r == 7'd0) ? CMP_W'(1) : CMP_W'(plen_r);
    if (m_raw > CMP_W'(PATTERN_MAX)) begin
      m_raw = CMP_W'(PATTERN_MAX);
    end
    if (m_raw > CMP_W'(build_len_r)) begin
      m_raw = CMP_W'(build_len_r);
    end
  end
  assign eff_len = LEN_W'(m_raw);

  // A shrunk length restarts the match from scratch.
  assign j0 = (match_r >= eff_len) ? '0 : match_r;

  // Loads must arrive in order; position zero always starts a new pattern.
  assign load_ok = ((in_pattern_position == 6'd0) ||
                    (CMP_W'(in_pattern_position) == CMP_W'(build_len_r))) &&
                   (CMP_W'(in_pattern_position) < CMP_W'(PATTERN_MAX));

  assign hit       = (p_rdata == sym_r);
  assign j_fin     = j_r + LEN_W'(hit);
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    build_len_nxt = build_len_r;
    match_nxt     = match_r;
    tpos_nxt      = tpos_r;
    found_nxt     = found_r;
    fms_nxt       = fms_r;
    j_nxt         = j_r;
    sym_nxt       = sym_r;
    pos_nxt       = pos_r;
    load_nxt      = load_r;
    done          = 1'b0;

    p_we    = 1'b0;
    p_waddr = IDX_W'(in_pattern_position);
    p_wdata = in_symbol;
    t_we    = 1'b0;
    t_waddr = pos_r;
    t_wdata = j_fin;
    p_raddr = j_r[IDX_W-1:0];
    t_raddr = IDX_W'(j_r - LEN_W'(1));

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          sym_nxt = in_symbol;
          pos_nxt = IDX_W'(in_pattern_position);
          case (in_mode)
            MODE_LOAD: begin
              if (load_ok) begin
                // Store the byte now; the walk below only reads earlier entries.
                p_we      = 1'b1;
                match_nxt = '0;
                tpos_nxt  = '0;
                found_nxt = 1'b0;
                fms_nxt   = '0;
                if (in_pattern_position == 6'd0) begin
                  t_we          = 1'b1;
                  t_waddr       = '0;
                  t_wdata       = '0;
                  build_len_nxt = LEN_W'(1);
                  done          = 1'b1;
                end else begin
                  t_raddr   = IDX_W'(in_pattern_position - 6'd1);
                  load_nxt  = 1'b1;
                  state_nxt = S_LDT;
                end
              end else begin
                done = 1'b1;
              end
            end
            MODE_TEXT: begin
              if (found_r) begin
                done = 1'b1;
              end else begin
                tpos_nxt = tpos_r + TB'(1);
                if (eff_len == '0) begin
                  match_nxt = '0;
                  done      = 1'b1;
                end else begin
                  j_nxt     = j0;
                  p_raddr   = j0[IDX_W-1:0];
                  t_raddr   = IDX_W'(j0 - LEN_W'(1));
                  load_nxt  = 1'b0;
                  state_nxt = S_CMP;
                end
              end
            end
            MODE_RESTART: begin
              match_nxt = '0;
              tpos_nxt  = '0;
              found_nxt = 1'b0;
              fms_nxt   = '0;
              done      = 1'b1;
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end

      S_LDT: begin
        // Table entry of the previous position seeds the walk.
        j_nxt     = t_rdata;
        p_raddr   = t_rdata[IDX_W-1:0];
        t_raddr   = IDX_W'(t_rdata - LEN_W'(1));
        state_nxt = S_CMP;
      end

      S_CMP: begin
        if ((j_r != '0) && !hit) begin
          // Fall back one table step and fetch the next candidate.
          j_nxt   = t_rdata;
          p_raddr = t_rdata[IDX_W-1:0];
          t_raddr = IDX_W'(t_rdata - LEN_W'(1));
        end else begin
          if (load_r) begin
            t_we          = 1'b1;
            build_len_nxt = LEN_W'(pos_r) + LEN_W'(1);
            match_nxt     = '0;
            tpos_nxt      = '0;
            found_nxt     = 1'b0;
            fms_nxt       = '0;
          end else begin
            match_nxt = j_fin;
            if (j_fin == eff_len) begin
              found_nxt = 1'b1;
              fms_nxt   = tpos_r - TB'(eff_len);
            end
          end
          done = 1'b1;
        end
      end

      S_OUT: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Hold the result back while the output register is still occupied.
    if (done) begin
      state_nxt = slot_free ? S_IDLE : S_OUT;
    end
  end

  assign out_load      = slot_free && (done || (state_r == S_OUT));
  assign out_valid_nxt = out_load ? 1'b1 : (out_valid_r && !out_ready);
  assign plen_nxt      = (cfg_valid && cfg_ready) ? cfg_pattern_length : plen_r;
  assign fms_ext       = 64'(fms_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      plen_r      <= 7'd1;
      build_len_r <= '0;
      match_r     <= '0;
      tpos_r      <= '0;
      found_r     <= 1'b0;
      fms_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      plen_r      <= plen_nxt;
      build_len_r <= build_len_nxt;
      match_r     <= match_nxt;
      tpos_r      <= tpos_nxt;
      found_r     <= found_nxt;
      fms_r       <= fms_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r    <= j_nxt;
    sym_r  <= sym_nxt;
    pos_r  <= pos_nxt;
    load_r <= load_nxt;
    if (out_load) begin
      out_found_r <= found_nxt;
      out_start_r <= found_nxt ? fms_ext[31:0] : 32'd0;
      out_count_r <= 7'(match_nxt);
    end
  end

  assign cfg_ready         = 1'b1;
  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_match_start   = out_start_r;
  assign out_matched_count = out_count_r;

`ifndef SYNTHESIS
  // The matched length never runs past the loaded pattern.
  a_match_within_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    match_r <= build_len_r)
    else $error("matched length exceeds loaded pattern length");

  // A latched match always carries a nonzero matched length.
  a_found_has_length: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> (match_r != '0))
    else $error("found set with zero matched length");

  // The walk index stays inside the memories.
  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (CMP_W'(j_r) < CMP_W'(PATTERN_MAX)))
    else $error("walk index out of range");

  // A result waiting in S_OUT is delivered before a new transaction is taken.
  a_out_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |-> !in_ready)
    else $error("input taken while a result is pending");
`endif

endmodule

`default_nettype wire

>>> src/kmps_ram.sv
// Simple dual-port synchronous memory, one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module kmps_ram
  import kmps_pkg::*;
#(
  parameter int DEPTH = PATTERN_MAX_DEF,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
